/* rtl/brep_pkg.sv */
package brep_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned RandW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned RateW  = 24;
  localparam int unsigned FracW  = 24;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RateW-1:0] RateReset = RateW'(2560);

  typedef enum logic [CfgIdxW-1:0] {
    CfgEmissionRate = 3'd0,
    CfgSingleBurst  = 3'd1,
    CfgDurationMin  = 3'd2,
    CfgDurationMax  = 3'd3,
    CfgRepeatMin    = 3'd4,
    CfgRepeatMax    = 3'd5,
    CfgStartDelay   = 3'd6
  } cfg_idx_e;

endpackage

/* rtl/brep_pick.sv */
module brep_pick (
  input  logic [brep_pkg::TimeW-1:0] lo_i,
  input  logic [brep_pkg::TimeW-1:0] hi_i,
  input  logic [brep_pkg::RandW-1:0] rnd_i,
  output logic [brep_pkg::TimeW-1:0] val_o
);
  import brep_pkg::*;

  localparam int unsigned ProdW = TimeW + RandW;

  logic              hi_ge;
  logic [TimeW-1:0]  span;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  prod_up;
  logic [TimeW-1:0]  step_dn;
  logic [TimeW-1:0]  step_up;

  // pick lo + r * (hi - lo), rounding toward lo when hi >= lo and away from lo when hi < lo
  assign hi_ge   = (hi_i >= lo_i);
  assign span    = hi_ge ? (hi_i - lo_i) : (lo_i - hi_i);
  assign prod    = ProdW'(rnd_i) * ProdW'(span);
  assign prod_up = prod + ProdW'({RandW{1'b1}});
  assign step_dn = prod[ProdW-1:RandW];
  assign step_up = prod_up[ProdW-1:RandW];
  assign val_o   = hi_ge ? (lo_i + step_dn) : (lo_i - step_up);

endmodule

/* rtl/burst_rate_emission_pacer_unit.sv */
// An input transfer is registered in the input stage, its result then in the output stage.
// Throughput: one tick per cycle while the master side accepts; the state loop closes
// through one rate x time multiply-add and the countdown compares, all combinational.
// Reset (rst_ni, asynchronous, active low): control and state registers take their reset
// values (data registers are not reset), the pacer starts active with an empty fraction and all countdowns at zero.
module burst_rate_emission_pacer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // elapsed_time[23:0], random_fraction[39:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // emit_count[15:0], emitting[16], zero[23:17]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [brep_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brep_pkg::RateW-1:0]   cfg_data_i
);
  import brep_pkg::*;

  localparam int unsigned ProdW = 2 * TimeW;
  localparam int unsigned DurW  = TimeW + 2;
  localparam int unsigned StW   = TimeW + 1;

  // configuration
  logic [RateW-1:0] rate_q;
  logic             single_q;
  logic [TimeW-1:0] dur_min_q, dur_max_q, rep_min_q, rep_max_q;

  // pacer state
  logic                   active_q, active_d;
  logic [FracW-1:0]       frac_q, frac_d;
  logic signed [DurW-1:0] dur_left_q, dur_left_d;
  logic signed [DurW-1:0] rep_left_q, rep_left_d;
  logic signed [StW-1:0]  start_left_q, start_left_d;

  // pipeline
  logic              in_valid_q;
  logic [TimeW-1:0]  in_dt_q;
  logic [RandW-1:0]  in_rnd_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_emit_q;
  logic              advance;
  logic              cfg_we;

  logic [ProdW-1:0]       sum;
  logic [TimeW-1:0]       whole;
  logic [CountW-1:0]      sat_count;
  logic [TimeW-1:0]       dur_pick, rep_pick;
  logic signed [DurW-1:0] dur_dec, rep_dec;
  logic signed [StW-1:0]  start_dec;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_emit_q, out_count_q};
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;

  brep_pick u_dur_pick (
    .lo_i  (dur_min_q),
    .hi_i  (dur_max_q),
    .rnd_i (in_rnd_q),
    .val_o (dur_pick)
  );

  brep_pick u_rep_pick (
    .lo_i  (rep_min_q),
    .hi_i  (rep_max_q),
    .rnd_i (in_rnd_q),
    .val_o (rep_pick)
  );

  assign sum       = ProdW'(frac_q) + ProdW'(rate_q) * ProdW'(in_dt_q);
  assign whole     = sum[ProdW-1:FracW];
  assign sat_count = (whole > TimeW'({CountW{1'b1}})) ? {CountW{1'b1}} : whole[CountW-1:0];
  assign dur_dec   = dur_left_q - $signed({2'b00, in_dt_q});
  assign rep_dec   = rep_left_q - $signed({2'b00, in_dt_q});
  assign start_dec = start_left_q - $signed({1'b0, in_dt_q});

  always_comb begin
    active_d     = active_q;
    frac_d       = frac_q;
    dur_left_d   = dur_left_q;
    rep_left_d   = rep_left_q;
    start_left_d = start_left_q;
    out_count_d  = '0;
    if (active_q) begin
      if (single_q) begin
        out_count_d = rate_q[RateW-1:RateW-CountW];
        active_d    = 1'b0;
        rep_left_d  = $signed({2'b00, rep_pick});
      end else begin
        out_count_d = sat_count;
        frac_d      = sum[FracW-1:0];
        if (dur_max_q != '0) begin
          dur_left_d = dur_dec;
          if (dur_dec[DurW-1] || dur_dec == '0) begin
            active_d   = 1'b0;
            rep_left_d = $signed({2'b00, rep_pick});
          end
        end
      end
    end else begin
      if (rep_max_q != '0) begin
        rep_left_d = rep_dec;
        if (rep_dec[DurW-1] || rep_dec == '0) begin
          active_d   = 1'b1;
          dur_left_d = $signed({2'b00, dur_pick});
        end
      end
      if (start_left_q != '0) begin
        start_left_d = start_dec;
        if (start_dec[StW-1] || start_dec == '0) begin
          active_d     = 1'b1;
          dur_left_d   = $signed({2'b00, dur_pick});
          start_left_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= RateReset;
      single_q     <= 1'b0;
      dur_min_q    <= '0;
      dur_max_q    <= '0;
      rep_min_q    <= '0;
      rep_max_q    <= '0;
      active_q     <= 1'b1;
      frac_q       <= '0;
      dur_left_q   <= '0;
      rep_left_q   <= '0;
      start_left_q <= '0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgEmissionRate: rate_q <= cfg_data_i;
          CfgSingleBurst:  single_q <= cfg_data_i[0];
          CfgDurationMin: begin
            dur_min_q <= cfg_data_i;
            if (active_q) dur_left_q <= $signed({2'b00, cfg_data_i});
            else          rep_left_q <= $signed({2'b00, rep_min_q});
          end
          CfgDurationMax: begin
            dur_max_q <= cfg_data_i;
            if (active_q) dur_left_q <= $signed({2'b00, dur_min_q});
            else          rep_left_q <= $signed({2'b00, rep_min_q});
          end
          CfgRepeatMin: begin
            rep_min_q <= cfg_data_i;
            if (active_q) dur_left_q <= $signed({2'b00, dur_min_q});
            else          rep_left_q <= $signed({2'b00, cfg_data_i});
          end
          CfgRepeatMax: begin
            rep_max_q <= cfg_data_i;
            if (active_q) dur_left_q <= $signed({2'b00, dur_min_q});
            else          rep_left_q <= $signed({2'b00, rep_min_q});
          end
          CfgStartDelay: begin
            start_left_q <= $signed({1'b0, cfg_data_i});
            if (cfg_data_i != '0) begin
              active_q   <= 1'b0;
              rep_left_q <= $signed({2'b00, rep_min_q});
            end
          end
          default: ;
        endcase
      end else if (advance) begin
        active_q     <= active_d;
        frac_q       <= frac_d;
        dur_left_q   <= dur_left_d;
        rep_left_q   <= rep_left_d;
        start_left_q <= start_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_dt_q  <= s_axis_tdata[TimeW-1:0];
      in_rnd_q <= s_axis_tdata[TimeW+RandW-1:TimeW];
    end
    if (advance) begin
      out_count_q <= out_count_d;
      out_emit_q  <= active_d;
    end
  end

  a_start_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_left_q[StW-1])
    else $error("start countdown went negative");

  a_idle_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !active_q |=> out_count_q == '0)
    else $error("count emitted while inactive");

  a_burst_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg_we && active_q && single_q |=> !active_q)
    else $error("single burst left pacer active");

  a_burst_keeps_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg_we && active_q && single_q |=> $stable(frac_q))
    else $error("single burst changed fraction");

endmodule
